// File: hdl/c_like_lexeme_splitter_macros.svh
// Assertion helpers for the lexeme splitter.
// Both sample on i_clk and are held off while i_rst_n is low.
`ifndef C_LIKE_LEXEME_SPLITTER_MACROS_SVH
`define C_LIKE_LEXEME_SPLITTER_MACROS_SVH
`ifndef SYNTH
// cond must hold at every clock edge
`define CLLS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
// cons must hold at the next clock edge after ante
`define CLLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CLLS_ASSERT_ALWAYS(label, cond, msg)
`define CLLS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: hdl/clls_pkg.sv
package clls_pkg;

    // scanner modes
    localparam logic [3:0] MODE_IDLE     = 4'd0;
    localparam logic [3:0] MODE_OPEQ     = 4'd1;
    localparam logic [3:0] MODE_OPDUP    = 4'd2;
    localparam logic [3:0] MODE_OPAMP    = 4'd3;
    localparam logic [3:0] MODE_MINUS    = 4'd4;
    localparam logic [3:0] MODE_MINUSDOT = 4'd5;
    localparam logic [3:0] MODE_DOT      = 4'd6;
    localparam logic [3:0] MODE_IDENT    = 4'd7;
    localparam logic [3:0] MODE_NUMBER   = 4'd8;

    // lexeme kinds
    localparam logic [2:0] KIND_PUNCT = 3'd0;
    localparam logic [2:0] KIND_OP    = 3'd1;
    localparam logic [2:0] KIND_IDENT = 3'd2;
    localparam logic [2:0] KIND_INT   = 3'd3;
    localparam logic [2:0] KIND_REAL  = 3'd4;
    localparam logic [2:0] KIND_OTHER = 3'd5;

    // special bytes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_MINUS  = 8'h2D;

    // output queue: one step may push up to three results
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int MAX_RES  = 3;

    typedef struct packed {
        logic [7:0]  lexeme_char;
        logic        first_of_lexeme;
        logic        last_of_lexeme;
        logic [2:0]  lexeme_kind;
        logic [31:0] token_index;
        logic        end_of_text;
        logic        last_of_run;
    } t_result;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == CH_USCORE);
    endfunction

    // space, tab, newline
    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A);
    endfunction

    // ( ) ; : [ ] { } ,
    function automatic logic is_punct(input logic [7:0] c);
        return (c == 8'h28) || (c == 8'h29) || (c == 8'h3B) || (c == 8'h3A)
            || (c == 8'h5B) || (c == 8'h5D) || (c == 8'h7B) || (c == 8'h7D)
            || (c == 8'h2C);
    endfunction

    // ~ ^ = ! * / %
    function automatic logic is_opeq(input logic [7:0] c);
        return (c == 8'h7E) || (c == 8'h5E) || (c == CH_EQ) || (c == 8'h21)
            || (c == 8'h2A) || (c == 8'h2F) || (c == 8'h25);
    endfunction

    // < > +
    function automatic logic is_opdup(input logic [7:0] c);
        return (c == 8'h3C) || (c == 8'h3E) || (c == 8'h2B);
    endfunction

    // & |
    function automatic logic is_opamp(input logic [7:0] c);
        return (c == 8'h26) || (c == 8'h7C);
    endfunction

endpackage

// File: hdl/c_like_lexeme_splitter.sv
// Streaming scanner for C-like source text, one byte per item.
// Input channel: i_valid / o_stall carry i_char_byte; a zero byte ends the text.
// Output channel: o_valid / i_stall carry one byte of a lexeme per item with its
// kind, first/last marks, lexeme number, end marker and last-of-run flag.
// Space, tab and newline between lexemes produce nothing.
// Flow: a byte is registered at acceptance and scanned from the input register;
// its results enter a 4-entry output queue, whose head drives the port. A byte
// whose lexeme end is not yet known is held until one or two more bytes arrive.
// Throughput: one byte per cycle while each byte yields at most one result and
// i_stall is low. A byte yielding two or three results sends them out one at a
// time; the scan stage waits until the queue has three free entries, so the
// output port (one result per cycle) sets the rate.
// Reset (synchronous, i_rst_n low) empties the queue, drops the input register,
// returns the scanner to idle and clears the lexeme counter. The end byte only
// flushes and returns to idle; the counter keeps running.
// With i_stall high the queue head holds. Once fewer than three entries are free
// the scan stage stops; o_stall rises while a byte waits in the input register.
`include "c_like_lexeme_splitter_macros.svh"
module c_like_lexeme_splitter
    import clls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_lexeme_char,
    output logic        o_first_of_lexeme,
    output logic        o_last_of_lexeme,
    output logic [2:0]  o_lexeme_kind,
    output logic [31:0] o_token_index,
    output logic        o_end_of_text,
    output logic        o_last_of_run
);

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // scanner state
    logic [3:0]  r_mode, n_mode;
    logic [7:0]  r_hold, n_hold;
    logic        r_first, n_first;
    logic        r_dot, n_dot;
    logic [31:0] r_cnt, n_cnt;

    // output queue
    t_result           r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0]  r_wr, r_rd;
    logic [OQ_AW:0]    r_oq_cnt;

    // step results
    t_result     w_res [MAX_RES];
    logic [1:0]  w_nres;
    logic [1:0]  w_inc;
    logic        w_start;
    logic        w_pair;
    logic [31:0] w_tok [4];
    logic        w_go;
    logic        w_in_acc;
    logic        w_pop;

    function automatic t_result mk_res(input logic [7:0] ch, input logic first,
                                       input logic last, input logic [2:0] kind,
                                       input logic eot, input logic [31:0] tok);
        t_result r;
        r.lexeme_char     = ch;
        r.first_of_lexeme = first;
        r.last_of_lexeme  = last;
        r.lexeme_kind     = kind;
        r.token_index     = tok;
        r.end_of_text     = eot;
        r.last_of_run     = 1'b0;
        return r;
    endfunction

    // handshakes
    assign w_go     = r_in_valid && (r_oq_cnt <= (OQ_AW+1)'(OQ_DEPTH - MAX_RES));
    assign o_stall  = r_in_valid && !w_go;
    assign w_in_acc = i_valid && !o_stall;
    assign o_valid  = (r_oq_cnt != '0);
    assign w_pop    = o_valid && !i_stall;

    // lexeme numbers a step can hand out
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_tok[k] = r_cnt + 32'(k);
        end
    end

    // held operator pairs with the incoming byte
    always_comb begin
        case (r_mode)
            MODE_OPEQ:  w_pair = (r_in_byte == CH_EQ);
            MODE_OPDUP: w_pair = (r_in_byte == CH_EQ) || (r_in_byte == r_hold);
            MODE_OPAMP: w_pair = (r_in_byte == r_hold);
            MODE_MINUS: w_pair = (r_in_byte == CH_EQ) || (r_in_byte == CH_MINUS);
            default:    w_pair = 1'b0;
        endcase
    end

    // one scan step: settle the held byte, then start on the new byte if needed
    always_comb begin
        n_mode  = r_mode;
        n_hold  = r_hold;
        n_first = r_first;
        n_dot   = r_dot;
        w_nres  = '0;
        w_inc   = '0;
        w_start = 1'b0;
        for (int k = 0; k < MAX_RES; k++) begin
            w_res[k] = '0;
        end

        case (r_mode)
            MODE_OPEQ, MODE_OPDUP, MODE_OPAMP, MODE_MINUS: begin
                if (w_pair) begin
                    w_res[w_nres] = mk_res(r_hold, 1'b1, 1'b0, KIND_OP, 1'b0, w_tok[w_inc]);
                    w_nres = w_nres + 2'd1;
                    w_res[w_nres] = mk_res(r_in_byte, 1'b0, 1'b1, KIND_OP, 1'b0,
                                           w_tok[w_inc]);
                    w_nres = w_nres + 2'd1;
                    w_inc = w_inc + 2'd1;
                    n_mode = MODE_IDLE;
                    n_first = 1'b0;
                    n_dot = 1'b0;
                end else if ((r_mode == MODE_MINUS) && is_digit(r_in_byte)) begin
                    // negative number
                    w_res[w_nres] = mk_res(r_hold, 1'b1, 1'b0, KIND_INT, 1'b0, w_tok[w_inc]);
                    w_nres = w_nres + 2'd1;
                    n_mode = MODE_NUMBER;
                    n_hold = r_in_byte;
                    n_first = 1'b0;
                    n_dot = 1'b0;
                end else if ((r_mode == MODE_MINUS) && (r_in_byte == CH_DOT)) begin
                    // "-." needs one more byte to decide
                    n_mode = MODE_MINUSDOT;
                end else begin
                    w_res[w_nres] = mk_res(r_hold, 1'b1, 1'b1, KIND_OP, 1'b0, w_tok[w_inc]);
                    w_nres = w_nres + 2'd1;
                    w_inc = w_inc + 2'd1;
                    n_mode = MODE_IDLE;
                    n_first = 1'b0;
                    n_dot = 1'b0;
                    w_start = 1'b1;
                end
            end
            MODE_MINUSDOT: begin
                if (is_digit(r_in_byte)) begin
                    w_res[w_nres] = mk_res(r_hold, 1'b1, 1'b0, KIND_REAL, 1'b0, w_tok[w_inc]);
                    w_nres = w_nres + 2'd1;
                    w_res[w_nres] = mk_res(CH_DOT, 1'b0, 1'b0, KIND_REAL, 1'b0, w_tok[w_inc]);
                    w_nres = w_nres + 2'd1;
                    n_mode = MODE_NUMBER;
                    n_hold = r_in_byte;
                    n_first = 1'b0;
                    n_dot = 1'b1;
                end else begin
                    // lone minus, then lone dot
                    w_res[w_nres] = mk_res(r_hold, 1'b1, 1'b1, KIND_OP, 1'b0, w_tok[w_inc]);
                    w_nres = w_nres + 2'd1;
                    w_inc = w_inc + 2'd1;
                    w_res[w_nres] = mk_res(CH_DOT, 1'b1, 1'b1, KIND_PUNCT, 1'b0,
                                           w_tok[w_inc]);
                    w_nres = w_nres + 2'd1;
                    w_inc = w_inc + 2'd1;
                    n_mode = MODE_IDLE;
                    n_first = 1'b0;
                    n_dot = 1'b0;
                    w_start = 1'b1;
                end
            end
            MODE_DOT: begin
                if (is_digit(r_in_byte)) begin
                    w_res[w_nres] = mk_res(r_hold, 1'b1, 1'b0, KIND_REAL, 1'b0, w_tok[w_inc]);
                    w_nres = w_nres + 2'd1;
                    n_mode = MODE_NUMBER;
                    n_hold = r_in_byte;
                    n_first = 1'b0;
                    n_dot = 1'b1;
                end else begin
                    w_res[w_nres] = mk_res(r_hold, 1'b1, 1'b1, KIND_PUNCT, 1'b0,
                                           w_tok[w_inc]);
                    w_nres = w_nres + 2'd1;
                    w_inc = w_inc + 2'd1;
                    n_mode = MODE_IDLE;
                    n_first = 1'b0;
                    n_dot = 1'b0;
                    w_start = 1'b1;
                end
            end
            MODE_IDENT: begin
                if (is_alpha(r_in_byte) || is_digit(r_in_byte)) begin
                    w_res[w_nres] = mk_res(r_hold, r_first, 1'b0, KIND_IDENT, 1'b0,
                                           w_tok[w_inc]);
                    w_nres = w_nres + 2'd1;
                    n_hold = r_in_byte;
                    n_first = 1'b0;
                end else begin
                    w_res[w_nres] = mk_res(r_hold, r_first, 1'b1, KIND_IDENT, 1'b0,
                                           w_tok[w_inc]);
                    w_nres = w_nres + 2'd1;
                    w_inc = w_inc + 2'd1;
                    n_mode = MODE_IDLE;
                    n_first = 1'b0;
                    n_dot = 1'b0;
                    w_start = 1'b1;
                end
            end
            MODE_NUMBER: begin
                if (is_digit(r_in_byte)) begin
                    w_res[w_nres] = mk_res(r_hold, r_first, 1'b0,
                                           r_dot ? KIND_REAL : KIND_INT, 1'b0, w_tok[w_inc]);
                    w_nres = w_nres + 2'd1;
                    n_hold = r_in_byte;
                    n_first = 1'b0;
                end else if ((r_in_byte == CH_DOT) && !r_dot) begin
                    w_res[w_nres] = mk_res(r_hold, r_first, 1'b0, KIND_INT, 1'b0,
                                           w_tok[w_inc]);
                    w_nres = w_nres + 2'd1;
                    n_hold = r_in_byte;
                    n_first = 1'b0;
                    n_dot = 1'b1;
                end else begin
                    w_res[w_nres] = mk_res(r_hold, r_first, 1'b1,
                                           r_dot ? KIND_REAL : KIND_INT, 1'b0, w_tok[w_inc]);
                    w_nres = w_nres + 2'd1;
                    w_inc = w_inc + 2'd1;
                    n_mode = MODE_IDLE;
                    n_first = 1'b0;
                    n_dot = 1'b0;
                    w_start = 1'b1;
                end
            end
            default: begin
                // idle, or an unused code
                n_mode = MODE_IDLE;
                n_first = 1'b0;
                n_dot = 1'b0;
                w_start = 1'b1;
            end
        endcase

        // new lexeme from the incoming byte
        if (w_start) begin
            if (r_in_byte == CH_NUL) begin
                w_res[w_nres] = mk_res(CH_NUL, 1'b0, 1'b0, KIND_PUNCT, 1'b1, w_tok[w_inc]);
                w_nres = w_nres + 2'd1;
                n_mode = MODE_IDLE;
            end else if (is_space(r_in_byte)) begin
                n_mode = MODE_IDLE;
            end else if (is_punct(r_in_byte)) begin
                w_res[w_nres] = mk_res(r_in_byte, 1'b1, 1'b1, KIND_PUNCT, 1'b0,
                                       w_tok[w_inc]);
                w_nres = w_nres + 2'd1;
                w_inc = w_inc + 2'd1;
            end else if (is_opeq(r_in_byte)) begin
                n_mode = MODE_OPEQ;
                n_hold = r_in_byte;
                n_first = 1'b1;
            end else if (is_opdup(r_in_byte)) begin
                n_mode = MODE_OPDUP;
                n_hold = r_in_byte;
                n_first = 1'b1;
            end else if (is_opamp(r_in_byte)) begin
                n_mode = MODE_OPAMP;
                n_hold = r_in_byte;
                n_first = 1'b1;
            end else if (r_in_byte == CH_MINUS) begin
                n_mode = MODE_MINUS;
                n_hold = r_in_byte;
                n_first = 1'b1;
            end else if (r_in_byte == CH_DOT) begin
                n_mode = MODE_DOT;
                n_hold = r_in_byte;
                n_first = 1'b1;
            end else if (is_alpha(r_in_byte)) begin
                n_mode = MODE_IDENT;
                n_hold = r_in_byte;
                n_first = 1'b1;
            end else if (is_digit(r_in_byte)) begin
                n_mode = MODE_NUMBER;
                n_hold = r_in_byte;
                n_first = 1'b1;
                n_dot = 1'b0;
            end else begin
                w_res[w_nres] = mk_res(r_in_byte, 1'b1, 1'b1, KIND_OTHER, 1'b0,
                                       w_tok[w_inc]);
                w_nres = w_nres + 2'd1;
                w_inc = w_inc + 2'd1;
            end
        end

        // mark the final result of this step
        if (w_nres != 2'd0) begin
            w_res[w_nres - 2'd1].last_of_run = 1'b1;
        end

        n_cnt = w_tok[w_inc];
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_go) begin
            r_in_valid <= 1'b0;
        end
        if (w_in_acc) begin
            r_in_byte <= i_char_byte;
        end
    end

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_hold  <= CH_NUL;
            r_first <= 1'b0;
            r_dot   <= 1'b0;
            r_cnt   <= '0;
        end else if (w_go) begin
            r_mode  <= n_mode;
            r_hold  <= n_hold;
            r_first <= n_first;
            r_dot   <= n_dot;
            r_cnt   <= n_cnt;
        end
    end

    // output queue storage
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (w_go && (2'(k) < w_nres)) begin
                r_oq[r_wr + OQ_AW'(k)] <= w_res[k];
            end
        end
    end

    // output queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr     <= '0;
            r_rd     <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (w_go) begin
                r_wr <= r_wr + OQ_AW'(w_nres);
            end
            if (w_pop) begin
                r_rd <= r_rd + OQ_AW'(1);
            end
            r_oq_cnt <= r_oq_cnt + (w_go ? (OQ_AW+1)'(w_nres) : '0)
                        - (OQ_AW+1)'(w_pop);
        end
    end

    // queue head drives the port
    assign o_lexeme_char     = r_oq[r_rd].lexeme_char;
    assign o_first_of_lexeme = r_oq[r_rd].first_of_lexeme;
    assign o_last_of_lexeme  = r_oq[r_rd].last_of_lexeme;
    assign o_lexeme_kind     = r_oq[r_rd].lexeme_kind;
    assign o_token_index     = r_oq[r_rd].token_index;
    assign o_end_of_text     = r_oq[r_rd].end_of_text;
    assign o_last_of_run     = r_oq[r_rd].last_of_run;

    // checks
    `CLLS_ASSERT_ALWAYS(a_oq_no_overflow, r_oq_cnt <= (OQ_AW+1)'(OQ_DEPTH),
        "output queue overflow")
    `CLLS_ASSERT_ALWAYS(a_stall_needs_item, !o_stall || r_in_valid, "stall without a held item")
    `CLLS_ASSERT_NEXT(a_end_to_idle, w_go && (r_in_byte == CH_NUL), r_mode == MODE_IDLE,
        "end byte did not return to idle")
    `CLLS_ASSERT_ALWAYS(a_end_marker_shape, !(o_valid && o_end_of_text)
        || (!o_first_of_lexeme && !o_last_of_lexeme && (o_lexeme_char == CH_NUL)),
        "malformed end marker")

endmodule

// File: sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import clls_pkg::*;

    localparam int OPENING_ROWS = 29;
    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_char_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_lexeme_char;
    logic        o_first_of_lexeme;
    logic        o_last_of_lexeme;
    logic [2:0]  o_lexeme_kind;
    logic [31:0] o_token_index;
    logic        o_end_of_text;
    logic        o_last_of_run;

    c_like_lexeme_splitter dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // scanner state kept alongside the block
    logic [3:0]  scan_state = MODE_IDLE;
    logic [7:0]  held_lead = 8'h00;
    logic [7:0]  held_dot = 8'h00;
    logic        held_starts = 1'b0;
    logic        fraction_seen = 1'b0;
    logic [31:0] lexeme_number = 32'd0;
    t_result     step_out[$];
    t_result     awaited_results[$];

    // side info that travels with each driven item
    logic        row_is_typed = 1'b0;
    t_result     row_result = '0;

    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          steady = 1'b0;

    string word_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string word_tail = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string digits    = "0123456789";
    string op_heads  = "~^=!*/%<>+&|-";
    string puncts    = "()[]{};:,";
    string blanks    = " \t\n";

    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        t_result    want;
    } t_opening_row;

    // directed opening; typed rows carry their result, the rest use the predictor
    t_opening_row opening_table [0:OPENING_ROWS-1] = '{
        {"(",   1'b1, "(",   1'b1, 1'b1, KIND_PUNCT, 32'd0, 1'b0, 1'b1},
        {8'hFF, 1'b1, 8'hFF, 1'b1, 1'b1, KIND_OTHER, 32'd1, 1'b0, 1'b1},
        {8'h01, 1'b1, 8'h01, 1'b1, 1'b1, KIND_OTHER, 32'd2, 1'b0, 1'b1},
        {CH_NUL, 1'b1, CH_NUL, 1'b0, 1'b0, KIND_PUNCT, 32'd3, 1'b1, 1'b1},
        {"a",   1'b0, 47'd0},   // identifier a_9
        {"_",   1'b0, 47'd0},
        {"9",   1'b0, 47'd0},
        {" ",   1'b0, 47'd0},
        {"<",   1'b0, 47'd0},   // << then =
        {"<",   1'b0, 47'd0},
        {"=",   1'b0, 47'd0},
        {"-",   1'b0, 47'd0},   // lone = ends, then -.5
        {".",   1'b0, 47'd0},
        {"5",   1'b0, 47'd0},
        {".",   1'b0, 47'd0},   // second dot ends the real, dot with no digit
        {"x",   1'b0, 47'd0},
        {"-",   1'b0, 47'd0},   // -3.7
        {"3",   1'b0, 47'd0},
        {".",   1'b0, 47'd0},
        {"7",   1'b0, 47'd0},
        {"&",   1'b0, 47'd0},   // &&
        {"&",   1'b0, 47'd0},
        {"|",   1'b0, 47'd0},   // | alone before a tab
        {"\t",  1'b0, 47'd0},
        {"-",   1'b0, 47'd0},   // -. then end of text: three results
        {".",   1'b0, 47'd0},
        {CH_NUL, 1'b0, 47'd0},
        {8'h0D, 1'b0, 47'd0},   // carriage return is not blank
        {"\n",  1'b0, 47'd0}
    };

    function automatic logic digit_byte(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic word_byte(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == CH_USCORE);
    endfunction

    function automatic void emit_byte(input logic [7:0] ch, input logic starts,
                                      input logic ends, input logic [2:0] kind,
                                      input logic eot);
        t_result r;
        r.lexeme_char     = ch;
        r.first_of_lexeme = starts;
        r.last_of_lexeme  = ends;
        r.lexeme_kind     = kind;
        r.token_index     = lexeme_number;
        r.end_of_text     = eot;
        r.last_of_run     = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void clear_scan();
        scan_state    = MODE_IDLE;
        held_lead     = 8'h00;
        held_dot      = 8'h00;
        held_starts   = 1'b0;
        fraction_seen = 1'b0;
    endfunction

    function automatic void hold_byte(input logic [3:0] mode, input logic [7:0] c,
                                      input logic starts);
        scan_state  = mode;
        held_lead   = c;
        held_starts = starts;
    endfunction

    // one-byte lexeme, counted at once
    function automatic void single_lexeme(input logic [7:0] c, input logic [2:0] kind);
        emit_byte(c, 1'b1, 1'b1, kind, 1'b0);
        lexeme_number++;
    endfunction

    // two-byte operator
    function automatic void close_pair(input logic [7:0] second);
        emit_byte(held_lead, 1'b1, 1'b0, KIND_OP, 1'b0);
        emit_byte(second, 1'b0, 1'b1, KIND_OP, 1'b0);
        lexeme_number++;
        clear_scan();
    endfunction

    // One scan of byte b; 0 means the mode moved on and b is scanned again.
    function automatic logic scan_feed(input logic [7:0] b);
        logic [7:0] h;
        h = held_lead;
        case (scan_state)
            MODE_OPEQ: begin
                if (b == CH_EQ) begin
                    close_pair(b);
                    return 1'b1;
                end
                single_lexeme(h, KIND_OP);
                clear_scan();
                return 1'b0;
            end
            MODE_OPDUP: begin
                if (b == CH_EQ || b == h) begin
                    close_pair(b);
                    return 1'b1;
                end
                single_lexeme(h, KIND_OP);
                clear_scan();
                return 1'b0;
            end
            MODE_OPAMP: begin
                if (b == h) begin
                    close_pair(b);
                    return 1'b1;
                end
                single_lexeme(h, KIND_OP);
                clear_scan();
                return 1'b0;
            end
            MODE_MINUS: begin
                if (b == CH_EQ || b == CH_MINUS) begin
                    close_pair(b);
                    return 1'b1;
                end
                if (digit_byte(b)) begin
                    emit_byte(h, 1'b1, 1'b0, KIND_INT, 1'b0);
                    hold_byte(MODE_NUMBER, b, 1'b0);
                    fraction_seen = 1'b0;
                    return 1'b1;
                end
                if (b == CH_DOT) begin
                    scan_state = MODE_MINUSDOT;
                    held_dot   = b;
                    return 1'b1;
                end
                single_lexeme(h, KIND_OP);
                clear_scan();
                return 1'b0;
            end
            MODE_MINUSDOT: begin
                if (digit_byte(b)) begin
                    emit_byte(h, 1'b1, 1'b0, KIND_REAL, 1'b0);
                    emit_byte(held_dot, 1'b0, 1'b0, KIND_REAL, 1'b0);
                    hold_byte(MODE_NUMBER, b, 1'b0);
                    fraction_seen = 1'b1;
                    return 1'b1;
                end
                // minus stands alone, the dot is rescanned
                single_lexeme(h, KIND_OP);
                hold_byte(MODE_DOT, held_dot, 1'b1);
                return 1'b0;
            end
            MODE_DOT: begin
                if (digit_byte(b)) begin
                    emit_byte(h, 1'b1, 1'b0, KIND_REAL, 1'b0);
                    hold_byte(MODE_NUMBER, b, 1'b0);
                    fraction_seen = 1'b1;
                    return 1'b1;
                end
                single_lexeme(h, KIND_PUNCT);
                clear_scan();
                return 1'b0;
            end
            MODE_IDENT: begin
                if (word_byte(b) || digit_byte(b)) begin
                    emit_byte(h, held_starts, 1'b0, KIND_IDENT, 1'b0);
                    hold_byte(MODE_IDENT, b, 1'b0);
                    return 1'b1;
                end
                emit_byte(h, held_starts, 1'b1, KIND_IDENT, 1'b0);
                lexeme_number++;
                clear_scan();
                return 1'b0;
            end
            MODE_NUMBER: begin
                if (digit_byte(b)) begin
                    emit_byte(h, held_starts, 1'b0, fraction_seen ? KIND_REAL : KIND_INT, 1'b0);
                    hold_byte(MODE_NUMBER, b, 1'b0);
                    return 1'b1;
                end
                if (b == CH_DOT && !fraction_seen) begin
                    emit_byte(h, held_starts, 1'b0, KIND_INT, 1'b0);
                    hold_byte(MODE_NUMBER, b, 1'b0);
                    fraction_seen = 1'b1;
                    return 1'b1;
                end
                emit_byte(h, held_starts, 1'b1, fraction_seen ? KIND_REAL : KIND_INT, 1'b0);
                lexeme_number++;
                clear_scan();
                return 1'b0;
            end
            default: begin
                // between lexemes
                clear_scan();
                case (b)
                    CH_NUL: emit_byte(CH_NUL, 1'b0, 1'b0, KIND_PUNCT, 1'b1);
                    " ", "\t", "\n": begin
                    end
                    "(", ")", ";", ":", "[", "]", "{", "}", ",": single_lexeme(b, KIND_PUNCT);
                    "~", "^", CH_EQ, "!", "*", "/", "%": hold_byte(MODE_OPEQ, b, 1'b1);
                    "<", ">", "+": hold_byte(MODE_OPDUP, b, 1'b1);
                    "&", "|": hold_byte(MODE_OPAMP, b, 1'b1);
                    CH_MINUS: hold_byte(MODE_MINUS, b, 1'b1);
                    CH_DOT: hold_byte(MODE_DOT, b, 1'b1);
                    default: begin
                        if (word_byte(b)) hold_byte(MODE_IDENT, b, 1'b1);
                        else if (digit_byte(b)) hold_byte(MODE_NUMBER, b, 1'b1);
                        else single_lexeme(b, KIND_OTHER);
                    end
                endcase
                return 1'b1;
            end
        endcase
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic logic [7:0] pick_char(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // mostly short gaps, a few long ones, none in steady stretches
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input logic [7:0] ch, input logic typed, input t_result want);
        int n;
        n = idle_span();
        if (n > 0) begin
            i_valid <= 1'b0;
            i_char_byte <= 8'($urandom_range(0, 255));
            repeat (n) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_char_byte  <= ch;
        row_is_typed <= typed;
        row_result   <= want;
        do @(posedge i_clk); while (o_stall);
    endtask

    // hold the sender until every awaited result is out
    task automatic drain_pause();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    // predict on accepted items, compare on accepted results
    always @(posedge i_clk) begin : scoreboard
        logic    taken;
        t_result r;
        t_result want;
        if (i_rst_n && i_valid && !o_stall) begin
            step_out.delete();
            taken = 1'b0;
            for (int pass = 0; pass < 4 && !taken; pass++) taken = scan_feed(i_char_byte);
            if (step_out.size() != 0) begin
                r = step_out.pop_back();
                r.last_of_run = 1'b1;
                step_out.push_back(r);
            end
            if (row_is_typed) awaited_results.push_back(row_result);
            else while (step_out.size() != 0) awaited_results.push_back(step_out.pop_front());
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_results.size() == 0) begin
                $error("result with nothing awaited: lexeme_char %02h", o_lexeme_char);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                check_field("lexeme_char", 32'(want.lexeme_char), 32'(o_lexeme_char));
                check_field("first_of_lexeme", 32'(want.first_of_lexeme),
                            32'(o_first_of_lexeme));
                check_field("last_of_lexeme", 32'(want.last_of_lexeme),
                            32'(o_last_of_lexeme));
                check_field("lexeme_kind", 32'(want.lexeme_kind), 32'(o_lexeme_kind));
                check_field("token_index", want.token_index, o_token_index);
                check_field("end_of_text", 32'(want.end_of_text), 32'(o_end_of_text));
                check_field("last_of_run", 32'(want.last_of_run), 32'(o_last_of_run));
            end
        end
    end

    // output-side stall pattern
    always @(posedge i_clk) begin
        if (stall_left == 0 && !steady && $urandom_range(0, 2) == 0) stall_left = idle_span();
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        logic [7:0] b;
        logic [7:0] lexeme_text[$];
        logic [7:0] head;
        int         sent;
        int         len;
        int         pick;
        bit         has_int;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < OPENING_ROWS; i++) begin
            send_item(opening_table[i].ch, opening_table[i].typed, opening_table[i].want);
        end
        drain_pause();

        // random text: mostly well-formed lexemes, some broken ones and noise
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            lexeme_text.delete();
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(12, 24)
                                                   : $urandom_range(1, 6);
                lexeme_text.push_back(pick_char(word_head));
                for (int k = 1; k < len; k++) lexeme_text.push_back(pick_char(word_tail));
            end else if (pick < 45) begin
                if ($urandom_range(0, 2) == 0) lexeme_text.push_back(CH_MINUS);
                has_int = ($urandom_range(0, 3) != 0);
                if (has_int) begin
                    repeat ($urandom_range(1, 5)) lexeme_text.push_back(pick_char(digits));
                end
                if (!has_int || $urandom_range(0, 1) == 0) begin
                    lexeme_text.push_back(CH_DOT);
                    repeat ($urandom_range(1, 4)) lexeme_text.push_back(pick_char(digits));
                    // a second dot ends the number
                    if ($urandom_range(0, 7) == 0) begin
                        lexeme_text.push_back(CH_DOT);
                        lexeme_text.push_back(pick_char(digits));
                    end
                end
            end else if (pick < 65) begin
                head = pick_char(op_heads);
                lexeme_text.push_back(head);
                case ($urandom_range(0, 3))
                    0: lexeme_text.push_back(CH_EQ);
                    1: lexeme_text.push_back(head);
                    2: lexeme_text.push_back(pick_char(op_heads));
                    default: begin
                    end
                endcase
            end else if (pick < 75) begin
                lexeme_text.push_back(pick_char(puncts));
            end else if (pick < 80) begin
                // dot or minus-dot with no digit after it
                if ($urandom_range(0, 1) == 0) lexeme_text.push_back(CH_MINUS);
                lexeme_text.push_back(CH_DOT);
                if ($urandom_range(0, 1) == 0) lexeme_text.push_back(pick_char(word_head));
                else lexeme_text.push_back(pick_char(puncts));
            end else if (pick < 95) begin
                lexeme_text.push_back(8'($urandom_range(0, 255)));
            end else begin
                lexeme_text.push_back(CH_NUL);
            end
            if ($urandom_range(0, 1) == 0) begin
                repeat ($urandom_range(1, 2)) lexeme_text.push_back(pick_char(blanks));
            end

            while (lexeme_text.size() != 0) begin
                b = lexeme_text.pop_front();
                send_item(b, 1'b0, '0);
                sent++;
                if ($urandom_range(0, 29) == 0) steady = !steady;
            end
            if ($urandom_range(0, 59) == 0) drain_pause();
        end

        // flush whatever is held, then wait out the tail
        send_item(CH_NUL, 1'b0, '0);
        drain_pause();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule
